>>> hw/rtl/hsbg_pkg.sv
`default_nettype none

package hsbg_pkg;

	typedef struct packed {
		logic [11:0] bin_index;
		logic [23:0] amplitude;
	} in_item_t;

	typedef struct packed {
		logic [11:0] bin_index_out;
		logic [23:0] amplitude_out;
		logic        in_band;
	} out_item_t;

	typedef struct packed {
		logic [11:0] centre_bin;
		logic [11:0] half_width;
		logic [12:0] range_begin;
		logic [12:0] range_end;
		logic [15:0] peak_gain;
		logic [15:0] phase_step;
	} cfg_t;

	// classified bin, front to back
	typedef struct packed {
		logic [11:0] bin_index;
		logic [23:0] amplitude;
		logic        in_band;
		logic        shape;
		logic [12:0] offset;
	} job_t;

	typedef enum logic [2:0] {
		REG_CENTRE_BIN  = 3'd0,
		REG_HALF_WIDTH  = 3'd1,
		REG_RANGE_BEGIN = 3'd2,
		REG_RANGE_END   = 3'd3,
		REG_PEAK_GAIN   = 3'd4,
		REG_PHASE_STEP  = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [16:0] ANGLE_PI      = 17'd65536;
	localparam logic [16:0] ANGLE_HALF_PI = 17'd32768;
	localparam logic [15:0] SINE_MAX      = 16'd32768;
	localparam logic [16:0] GAIN_UNITY_Q12 = 17'd4096;
	localparam logic [30:0] UNITY_Q27     = 31'd134217728;
	localparam logic [23:0] AMP_MAX       = 24'hFFFFFF;

endpackage

`default_nettype wire

>>> hw/rtl/half_sine_band_gain_top.sv
// Bins pass the 4-entry job queue, a five-stage multiply/ROM pipeline and
// the 8-entry result queue (empty low). Throughput: one bin per cycle while a
// result slot is free to reserve; the pipeline itself never stalls.
// Reset (arst_n low, asynchronous): queues empty, pipeline idle, registers at
// centre 0, half width 0, range 0..4096, peak gain 1.0, phase step 0.
`default_nettype none

module half_sine_band_gain_top
	import hsbg_pkg::*;
#(
	parameter int BINS             = 4096,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire in_item_t               item,
	output logic                        empty,
	input  wire logic                   pop,
	output out_item_t                   result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	job_t      job_in;
	job_t      job_out;
	logic      job_empty;
	logic      job_pop;
	logic      res_push;
	out_item_t res_in;
	logic      res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_bin  <= '0;
			cfg_q.half_width  <= '0;
			cfg_q.range_begin <= '0;
			cfg_q.range_end   <= 13'd4096;
			cfg_q.peak_gain   <= 16'd4096;
			cfg_q.phase_step  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTRE_BIN:  cfg_q.centre_bin  <= cfg_data[11:0];
				REG_HALF_WIDTH:  cfg_q.half_width  <= cfg_data[11:0];
				REG_RANGE_BEGIN: cfg_q.range_begin <= cfg_data[12:0];
				REG_RANGE_END:   cfg_q.range_end   <= cfg_data[12:0];
				REG_PEAK_GAIN:   cfg_q.peak_gain   <= cfg_data;
				REG_PHASE_STEP:  cfg_q.phase_step  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hsbg_front #(
		.BINS(BINS)
	) u_front (
		.cfg  (cfg_q),
		.item (item),
		.job  (job_in)
	);

	hsbg_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(MID_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	hsbg_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_pop   (pop && !empty),
		.res_push  (res_push),
		.res       (res_in)
	);

	hsbg_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	// slots are reserved at issue, so the result queue cannot overflow
	logic unused_res_full;
	assign unused_res_full = res_full;

endmodule

`default_nettype wire

>>> hw/rtl/hsbg_fifo.sv
`default_nettype none

module hsbg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/hsbg_front.sv
`default_nettype none

module hsbg_front
	import hsbg_pkg::*;
#(
	parameter int BINS = 4096
) (
	input  wire cfg_t     cfg,
	input  wire in_item_t item,
	output job_t          job
);

	logic signed [13:0] lo;
	logic signed [13:0] hi;
	logic        [16:0] rend_w;
	logic        [12:0] rend;
	logic signed [13:0] win_begin;
	logic signed [13:0] win_end;
	logic signed [13:0] k;
	logic signed [13:0] diff;
	logic               in_win;

	always_comb begin
		lo = $signed({2'b00, cfg.centre_bin}) - $signed({2'b00, cfg.half_width});
		hi = $signed({2'b00, cfg.centre_bin}) + $signed({2'b00, cfg.half_width})
			+ 14'sd1;
		rend_w = ({4'b0, cfg.range_end} > 17'(BINS)) ? 17'(BINS) : {4'b0, cfg.range_end};
		rend   = rend_w[12:0];
		win_begin = (lo > $signed({1'b0, cfg.range_begin})) ? lo
			: $signed({1'b0, cfg.range_begin});
		win_end = (hi < $signed({1'b0, rend})) ? hi : $signed({1'b0, rend});
		k      = $signed({2'b00, item.bin_index});
		in_win = (k >= win_begin) && (k < win_end);
		diff   = k - lo;

		job.bin_index = item.bin_index;
		job.amplitude = item.amplitude;
		job.in_band   = in_win;
		job.shape     = in_win && (cfg.half_width != '0) && (cfg.phase_step != '0);
		job.offset    = diff[12:0];
	end

endmodule

`default_nettype wire

>>> hw/rtl/hsbg_back.sv
`default_nettype none

module hsbg_back
	import hsbg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      job_empty,
	input  wire job_t      job,
	output logic           job_pop,
	input  wire logic      res_pop,
	output logic           res_push,
	output out_item_t      res
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = 16 + AW;
	localparam int IW = PW - 14;
	localparam int RW = $clog2(OUT_DEPTH + 1);

	typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

	function automatic sine_rom_t build_rom();
		sine_rom_t   r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
			x  = (HALF_PI_Q30 * 64'(j) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 64'd110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			s  = (s + 64'd16384) >> 15;
			r[j] = (s > 64'(SINE_MAX)) ? SINE_MAX : s[15:0];
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	logic [RW-1:0] resv_q;
	logic          issue;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [11:0]   k_s1, k_s2, k_s3, k_s4, k_s5;
	logic [23:0]   amp_s1, amp_s2, amp_s3, amp_s4, amp_s5;
	logic          band_s1, band_s2, band_s3, band_s4, band_s5;
	logic          shape_s1, shape_s2, shape_s3;
	logic [28:0]   angle_s1;
	logic [PW-1:0] prod_s2;
	logic [15:0]   sine_s3;
	logic [30:0]   gain_s4;
	logic [54:0]   prod_s5;

	logic [16:0]        angle_cl;
	logic [16:0]        angle_fold;
	logic [PW:0]        idx_sum;
	logic [IW-1:0]      idx_full;
	logic [AW-1:0]      idx;
	logic signed [16:0] gain_delta;
	logic signed [33:0] gain_prod;
	logic signed [33:0] gain_full;
	logic [55:0]        round_sum;
	logic [28:0]        scaled;

	// reserve an output slot before issuing, so the pipeline never stalls
	assign issue   = !job_empty && (resv_q < RW'(OUT_DEPTH));
	assign job_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			if (issue && !res_pop) begin
				resv_q <= resv_q + RW'(1);
			end else if (res_pop && !issue) begin
				resv_q <= resv_q - RW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		angle_cl   = (angle_s1 > 29'(ANGLE_PI)) ? ANGLE_PI : angle_s1[16:0];
		angle_fold = (angle_cl > ANGLE_HALF_PI) ? (ANGLE_PI - angle_cl) : angle_cl;
		idx_sum    = (PW + 1)'(prod_s2) + (PW + 1)'(16384);
		idx_full   = idx_sum[PW:15];
		idx        = (idx_full > IW'(SINE_TABLE_DEPTH)) ? AW'(SINE_TABLE_DEPTH)
			: idx_full[AW-1:0];
		gain_delta = $signed({1'b0, cfg.peak_gain}) - $signed(GAIN_UNITY_Q12);
		gain_prod  = 34'(gain_delta) * 34'($signed({1'b0, sine_s3}));
		gain_full  = gain_prod + $signed(34'(UNITY_Q27));
		round_sum  = {1'b0, prod_s5} + 56'd67108864;
		scaled     = round_sum[55:27];
	end

	always_ff @(posedge clk) begin
		k_s1     <= job.bin_index;
		amp_s1   <= job.amplitude;
		band_s1  <= job.in_band;
		shape_s1 <= job.shape;
		angle_s1 <= 29'(cfg.phase_step) * 29'(job.offset);

		k_s2     <= k_s1;
		amp_s2   <= amp_s1;
		band_s2  <= band_s1;
		shape_s2 <= shape_s1;
		prod_s2  <= PW'(angle_fold[15:0]) * PW'(SINE_TABLE_DEPTH);

		k_s3     <= k_s2;
		amp_s3   <= amp_s2;
		band_s3  <= band_s2;
		shape_s3 <= shape_s2;
		sine_s3  <= SINE_ROM[idx];

		k_s4    <= k_s3;
		amp_s4  <= amp_s3;
		band_s4 <= band_s3;
		if (!shape_s3) begin
			gain_s4 <= UNITY_Q27;
		end else if (gain_full < 0) begin
			gain_s4 <= '0;
		end else begin
			gain_s4 <= gain_full[30:0];
		end

		k_s5    <= k_s4;
		amp_s5  <= amp_s4;
		band_s5 <= band_s4;
		prod_s5 <= 55'(amp_s4) * 55'(gain_s4);
	end

	assign res_push          = v_s5;
	assign res.bin_index_out = k_s5;
	assign res.amplitude_out = (scaled[28:24] != '0) ? AMP_MAX : scaled[23:0];
	assign res.in_band       = band_s5;

endmodule

`default_nettype wire

>>> tb/sv/half_sine_band_gain_top_test.sv
`timescale 1ns / 100ps

module half_sine_band_gain_top_test;
	import hsbg_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int BIN_COUNT   = 4096;
	localparam int SINE_DEPTH  = 1024;
	localparam int LATENCY     = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_BINS  = 128;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t bin_in = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t bin_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	in_item_t pending_bins[$];
	out_item_t shaped_bins[$];
	logic [15:0] sine_q15 [0:SINE_DEPTH];

	logic [11:0] cur_centre = 12'd0;
	logic [11:0] cur_half = 12'd0;
	logic [12:0] cur_begin = 13'd0;
	logic [12:0] cur_end = 13'd4096;
	logic [15:0] cur_peak = 16'd4096;
	logic [15:0] cur_step = 16'd0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	half_sine_band_gain_top #(
		.BINS(BIN_COUNT),
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(bin_in),
		.empty(empty),
		.pop(pop),
		.result(bin_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic out_item_t shape_bin(in_item_t it);
		longint k, lo, hi, rend, win_lo, win_hi, ang, idx, s, g;
		longint unsigned prod;
		out_item_t r;
		k = longint'(it.bin_index);
		lo = longint'(cur_centre) - longint'(cur_half);
		hi = longint'(cur_centre) + longint'(cur_half) + 1;
		rend = longint'(cur_end);
		if (rend > BIN_COUNT)
			rend = BIN_COUNT;
		win_lo = (lo > longint'(cur_begin)) ? lo : longint'(cur_begin);
		win_hi = (hi < rend) ? hi : rend;
		if (win_hi < win_lo)
			win_hi = win_lo;
		r.bin_index_out = it.bin_index;
		r.amplitude_out = it.amplitude;
		r.in_band = (k >= win_lo) && (k < win_hi);
		if (r.in_band && cur_half != 0 && cur_step != 0) begin
			ang = longint'(cur_step) * (k - lo);
			if (ang > 65536)
				ang = 65536;
			if (ang > 32768)
				ang = 65536 - ang;
			idx = (ang * SINE_DEPTH + 16384) >>> 15;
			if (idx > SINE_DEPTH)
				idx = SINE_DEPTH;
			s = longint'(sine_q15[idx]);
			g = 64'sd134217728 + (longint'(cur_peak) - 4096) * s;
			if (g < 0)
				g = 0;
			prod = (longint'(it.amplitude) * g + 64'd67108864) >> 27;
			if (prod > 64'hFFFFFF)
				prod = 64'hFFFFFF;
			r.amplitude_out = prod[23:0];
		end
		return r;
	endfunction

	function automatic void add_bin(logic [11:0] k, logic [23:0] a);
		in_item_t it;
		it.bin_index = k;
		it.amplitude = a;
		pending_bins.push_back(it);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(cfg_t c);
		write_reg(REG_CENTRE_BIN, 16'(c.centre_bin));
		write_reg(REG_HALF_WIDTH, 16'(c.half_width));
		write_reg(REG_RANGE_BEGIN, 16'(c.range_begin));
		write_reg(REG_RANGE_END, 16'(c.range_end));
		write_reg(REG_PEAK_GAIN, c.peak_gain);
		write_reg(REG_PHASE_STEP, c.phase_step);
		#1;
	endtask

	// ends just after a falling edge, with nothing queued or outstanding
	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (pending_bins.size() != 0 || shaped_bins.size() != 0);
	endtask

	// sender
	always @(negedge clk) begin
		if (pending_bins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			bin_in <= pending_bins[0];
		end else begin
			push <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTRE_BIN:  cur_centre = cfg_data[11:0];
				REG_HALF_WIDTH:  cur_half = cfg_data[11:0];
				REG_RANGE_BEGIN: cur_begin = cfg_data[12:0];
				REG_RANGE_END:   cur_end = cfg_data[12:0];
				REG_PEAK_GAIN:   cur_peak = cfg_data;
				REG_PHASE_STEP:  cur_step = cfg_data;
				default: ;
			endcase
		end
		if (push && !full) begin
			shaped_bins.push_back(shape_bin(bin_in));
			void'(pending_bins.pop_front());
		end
		if (pop && !empty) begin
			if (shaped_bins.size() == 0) begin
				mismatches++;
				$display("%0t unexpected transaction: expected none got %h", $time, bin_out);
			end else begin
				want = shaped_bins.pop_front();
				if (bin_out.bin_index_out !== want.bin_index_out) begin
					mismatches++;
					$display("%0t bin_index_out: expected %h got %h", $time,
						want.bin_index_out, bin_out.bin_index_out);
				end
				if (bin_out.amplitude_out !== want.amplitude_out) begin
					mismatches++;
					$display("%0t amplitude_out: expected %h got %h", $time,
						want.amplitude_out, bin_out.amplitude_out);
				end
				if (bin_out.in_band !== want.in_band) begin
					mismatches++;
					$display("%0t in_band: expected %b got %b", $time,
						want.in_band, bin_out.in_band);
				end
			end
		end
	end

	initial begin
		longint unsigned x, x2, t, sv;
		cfg_t c;
		int p, n, span, kk, r;
		for (int j = 0; j <= SINE_DEPTH; j++) begin
			x = (64'd1686629713 * j + SINE_DEPTH / 2) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t = 64'd1073741824 - x2 / 110;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 72;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
			t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
			sv = (x * t) >> 30;
			sv = (sv + 16384) >> 15;
			if (sv > 32768)
				sv = 32768;
			sine_q15[j] = sv[15:0];
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 16;
		recv_idle_pct = 47;
		#1;

		// reset settings: unity gain, only bin 0 in band
		add_bin(12'd0, 24'hFFFFFF);
		add_bin(12'd0, 24'h000000);
		add_bin(12'd1, 24'h555555);
		add_bin(12'd4095, 24'hAAAAAA);
		drain();

		// full-scale boost, angle past pi at the window top
		c = '{centre_bin: 12'd100, half_width: 12'd20, range_begin: 13'd0,
			range_end: 13'd4096, peak_gain: 16'hFFFF, phase_step: 16'd1700};
		write_all(c);
		add_bin(12'd79, 24'hFFFFFF);
		add_bin(12'd80, 24'hFFFFFF);
		add_bin(12'd90, 24'h123456);
		add_bin(12'd100, 24'hFFFFFF);
		add_bin(12'd100, 24'h000001);
		add_bin(12'd110, 24'h000FFF);
		add_bin(12'd119, 24'h800000);
		add_bin(12'd120, 24'h7FFFFF);
		add_bin(12'd121, 24'hFFFFFF);
		drain();

		// zero gain at centre, window clipped on both sides
		c = '{centre_bin: 12'd5, half_width: 12'd10, range_begin: 13'd3,
			range_end: 13'd8, peak_gain: 16'd0, phase_step: 16'd3277};
		write_all(c);
		add_bin(12'd2, 24'hFFFFFF);
		add_bin(12'd3, 24'hFFFFFF);
		add_bin(12'd5, 24'hFFFFFF);
		add_bin(12'd7, 24'h3C3C3C);
		add_bin(12'd8, 24'hFFFFFF);
		drain();

		// zero half width at top bin, range end beyond bin count
		c = '{centre_bin: 12'd4095, half_width: 12'd0, range_begin: 13'd0,
			range_end: 13'd8191, peak_gain: 16'hFFFF, phase_step: 16'd3277};
		write_all(c);
		add_bin(12'd4095, 24'hFFFFFF);
		add_bin(12'd4094, 24'hFFFFFF);
		drain();

		// empty clipped window
		c = '{centre_bin: 12'd50, half_width: 12'd10, range_begin: 13'd200,
			range_end: 13'd100, peak_gain: 16'hFFFF, phase_step: 16'hFFFF};
		write_all(c);
		add_bin(12'd50, 24'hFFFFFF);
		add_bin(12'd100, 24'hFFFFFF);
		add_bin(12'd200, 24'hFFFFFF);
		drain();

		for (p = 0; p < RAND_PHASES; p++) begin
			if (p < RAND_PHASES / 3) begin
				send_idle_pct = 16;
				recv_idle_pct = 47;
			end else if (p < 2 * RAND_PHASES / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			r = $urandom_range(7);
			c.centre_bin = (r == 0) ? 12'd0 : (r == 1) ? 12'hFFF : 12'($urandom);
			r = $urandom_range(7);
			c.half_width = (r == 0) ? 12'd0 : (r == 1) ? 12'hFFF :
				(r == 2) ? 12'($urandom_range(1, 2048)) : 12'($urandom_range(1, 64));
			r = $urandom_range(7);
			c.range_begin = (r < 4) ? 13'd0 : (r == 4) ? 13'h1FFF :
				13'($urandom_range(0, 4096));
			r = $urandom_range(7);
			c.range_end = (r < 4) ? 13'd4096 : (r == 4) ? 13'h1FFF :
				13'($urandom_range(0, 4096));
			r = $urandom_range(7);
			c.peak_gain = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
				(r == 2) ? 16'd4096 : 16'($urandom);
			r = $urandom_range(7);
			if (r == 0 || c.half_width == 0)
				c.phase_step = (r < 4) ? 16'd0 : 16'($urandom);
			else if (r == 1)
				c.phase_step = 16'hFFFF;
			else if (r == 2)
				c.phase_step = 16'($urandom);
			else
				c.phase_step = 16'(65536 / (2 * int'(c.half_width)));
			write_all(c);

			span = 2 * int'(c.half_width) + 4;
			for (n = 0; n < PHASE_BINS; n++) begin
				// sender holds off until everything in flight has come back
				if (p % 3 == 1 && n == PHASE_BINS / 2)
					drain();
				if ($urandom_range(9) < 8)
					kk = int'(c.centre_bin) - int'(c.half_width) - 2 +
						int'($urandom_range(0, span));
				else
					kk = int'($urandom_range(0, 4095));
				r = $urandom_range(7);
				add_bin(12'(kk), (r == 0) ? 24'hFFFFFF : (r == 1) ? 24'h000000 :
					(r == 2) ? 24'($urandom_range(0, 255)) : 24'($urandom));
			end
			drain();
		end

		repeat (4 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
